### src/tbwd_pkg.sv
// Package with shared types and fp helpers for the two-bit weight dequantizer.
package tbwd_pkg;

   typedef enum logic {
      ACT_SCALE = 1'b0,
      ACT_CODES = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CODE_NEG  = 2'd0,
      CODE_ZERO = 2'd1,
      CODE_ONE  = 2'd2,
      CODE_TWO  = 2'd3
   } code_type;

   localparam logic [31:0] FP32_EXP_MASK    = 32'h7F80_0000;
   localparam logic [31:0] FP32_MANT_MASK   = 32'h007F_FFFF;
   localparam logic [31:0] FP32_SIGN        = 32'h8000_0000;
   localparam logic [31:0] FP32_QUIET       = 32'h0040_0000;
   localparam logic [31:0] FP32_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP32_EXP_ONE     = 32'h0080_0000;

   // Exact half to single conversion.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] sign;
      logic [4:0]  ex;
      logic [9:0]  mant;
      logic [3:0]  lz;
      logic [10:0] m;
      logic [7:0]  fexp;
      sign = {h[15], 31'd0};
      ex   = h[14:10];
      mant = h[9:0];
      lz   = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (mant[i]) lz = 4'(10 - i);
      end
      m = {1'b0, mant} << lz;
      fexp = 8'd113 - {4'd0, lz};
      if (ex == 5'd0) begin
         if (mant == 10'd0) half_to_single = sign;
         else half_to_single = sign | {1'b0, fexp, m[9:0], 13'd0};
      end else if (ex == 5'h1F) begin
         half_to_single = sign | FP32_EXP_MASK | {9'd0, mant, 13'd0};
      end else begin
         half_to_single = sign | {1'b0, 8'({3'd0, ex} + 8'd112), mant, 13'd0};
      end
   endfunction

endpackage

### src/two_bit_weight_dequantizer.sv
// Top level of the two-bit weight dequantizer.
// Each req word is either a scale load (tuser 0, fp16 in tdata[15:0]) or a code byte
// (tuser 1, codes in tdata[23:16]). A scale load updates the block scale and gives no
// rsp word; a code byte gives one rsp word with four fp32 weights. One word is taken
// every cycle unless stalled; a result appears in the cycle after acceptance,
// via one output register that stalls the input only when full and not drained.
module two_bit_weight_dequantizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // scale_half [15:0], code_byte [23:16]
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // weight_a, weight_b, weight_c, weight_d from bit 0
);
   import tbwd_pkg::*;

   logic         take, load, emit;
   logic [31:0]  scale;
   logic [127:0] weights;
   logic         valid_ff, valid_in;
   logic [127:0] data_ff, data_in;

   assign req_tready = !valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign load = take && (action_type'(req_tuser) == ACT_SCALE);
   assign emit = take && (action_type'(req_tuser) == ACT_CODES);

   tbwd_scale u_scale (
      .clock(clock), .reset(reset), .load(load),
      .scale_half(req_tdata[15:0]), .scale(scale)
   );

   for (genvar i = 0; i < 4; i++) begin : g_lane
      tbwd_lane u_lane (
         .code(req_tdata[16 + 2*i +: 2]), .scale(scale), .weight(weights[32*i +: 32])
      );
   end

   assign valid_in = emit || (valid_ff && !rsp_tready);
   assign data_in  = emit ? weights : data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_emit: assert property (@(posedge clock) disable iff (reset) emit |=> rsp_tvalid)
      else $error("code word gave no result");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result lost");
   a_noload: assert property (@(posedge clock) disable iff (reset)
      !(load && emit)) else $error("load and emit together");
endmodule

### src/tbwd_scale.sv
// Block scale register: converts and holds the current fp32 scale.
module tbwd_scale (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [15:0] scale_half,
   output logic [31:0] scale
);
   import tbwd_pkg::*;

   logic [31:0] scale_ff, scale_in;

   assign scale_in = load ? half_to_single(scale_half) : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) scale_ff <= 32'd0;
      else scale_ff <= scale_in;
   end

   assign scale = scale_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(load) |-> $stable(scale_ff)) else $error("scale changed without load");
   a_reset: assert property (@(posedge clock) $past(reset) |-> scale_ff == 32'd0)
      else $error("scale not cleared by reset");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      $past(load) && $past(scale_half[14:0]) == 15'd0 |-> scale_ff[30:0] == 31'd0)
      else $error("half zero not kept as zero");
endmodule

### src/tbwd_lane.sv
// One weight lane: multiplies the scale by code minus one on fp32 bits.
module tbwd_lane (
   input  logic [1:0]  code,
   input  logic [31:0] scale,
   output logic [31:0] weight
);
   import tbwd_pkg::*;

   logic is_nan, is_inf, is_zero;

   assign is_nan  = ((scale & FP32_EXP_MASK) == FP32_EXP_MASK) &&
                    ((scale & FP32_MANT_MASK) != 32'd0);
   assign is_inf  = ((scale & FP32_EXP_MASK) == FP32_EXP_MASK) &&
                    ((scale & FP32_MANT_MASK) == 32'd0);
   assign is_zero = scale[30:0] == 31'd0;

   always_comb begin
      weight = scale;
      if (is_nan) begin
         weight = scale | FP32_QUIET;
      end else begin
         unique case (code_type'(code))
            CODE_NEG:  weight = scale ^ FP32_SIGN;
            CODE_ZERO: weight = is_inf ? FP32_DEFAULT_NAN : (scale & FP32_SIGN);
            CODE_ONE:  weight = scale;
            CODE_TWO:  weight = (is_zero || is_inf) ? scale : scale + FP32_EXP_ONE;
            default:   weight = scale;
         endcase
      end
   end
endmodule
